### sv/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared widths, codes, types and helpers for the searchable sortable fifo.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int CAP_W  = 5;
  localparam int ST_W   = 2;
  localparam int LW     = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SORT   = 3'd4;

  localparam logic [ST_W-1:0] STS_OK     = 2'd0;
  localparam logic [ST_W-1:0] STS_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] STS_FULL   = 2'd2;
  localparam logic [ST_W-1:0] STS_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SEARCH,
    ST_SORT_FIRST,
    ST_SORT_STEP,
    ST_SORT_END
  } state_e;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  // ring slot of a position counted from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

### sv/ssf_ram.sv
// ----------------------------------------------------------------------------
// ssf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ssf_ctrl.sv
// ----------------------------------------------------------------------------
// ssf_ctrl
// Sequencer for the ring: pointers, occupancy, search walk, bubble sort
// passes over the entry RAM, and the result register.
// ----------------------------------------------------------------------------
module ssf_ctrl import ssf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CAP_W-1:0]  capacity_i,
  output mem_req_t          mem_o,
  input  logic [DATA_W-1:0] rdata_i,
  output logic              done_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic              found_o,
  output logic [POS_W-1:0]  found_position_o,
  output logic [ST_W-1:0]   status_o,
  output logic [POS_W-1:0]  occupancy_o
);

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     last_q, last_d;
  logic [DATA_W-1:0] carry_q, carry_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  fpos_q, fpos_d;
  logic [ST_W-1:0]   status_q, status_d;

  logic [LW-1:0] limit;
  logic [LW-1:0] cap_ext;
  logic [CW-1:0] idx_next;

  always_comb begin
    cap_ext = LW'(capacity_i);
    limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  end

  assign idx_next = CW'(idx_q) + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    last_q   <= last_d;
    carry_q  <= carry_d;
    key_q    <= key_d;
    data_q   <= data_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    last_d   = last_q;
    carry_d  = carry_q;
    key_d    = key_q;
    done_d   = 1'b0;
    data_d   = data_q;
    found_d  = found_q;
    fpos_d   = fpos_q;
    status_d = status_q;
    mem_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          done_d   = 1'b1;
          data_d   = '0;
          found_d  = 1'b0;
          fpos_d   = '0;
          status_d = STS_OK;
          case (action_i)
            ACT_ENQ: begin
              if (LW'(count_q) >= limit) begin
                status_d = STS_FULL;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = slot(head_q, count_q[AW-1:0]);
                mem_o.wdata = value_i;
                count_d     = count_q + CW'(1);
              end
            end
            ACT_DEQ: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else begin
                done_d      = 1'b0;
                mem_o.raddr = head_q;
                state_d     = ST_DEQ;
              end
            end
            ACT_SEARCH: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else begin
                done_d      = 1'b0;
                mem_o.raddr = head_q;
                idx_d       = '0;
                key_d       = value_i;
                state_d     = ST_SEARCH;
              end
            end
            ACT_UPDATE: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else if (position_i == '0 || LW'(position_i) > LW'(count_q)) begin
                status_d = STS_BADPOS;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = slot(head_q, AW'(position_i - POS_W'(1)));
                mem_o.wdata = value_i;
              end
            end
            ACT_SORT: begin
              if (count_q == '0) begin
                status_d = STS_EMPTY;
              end else if (count_q != CW'(1)) begin
                done_d      = 1'b0;
                mem_o.raddr = head_q;
                idx_d       = AW'(1);
                last_d      = AW'(count_q - CW'(1));
                state_d     = ST_SORT_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_DEQ: begin
        done_d   = 1'b1;
        data_d   = rdata_i;
        status_d = STS_OK;
        head_d   = slot(head_q, AW'(1));
        count_d  = count_q - CW'(1);
        state_d  = ST_IDLE;
      end

      ST_SEARCH: begin
        if (rdata_i == key_q) begin
          done_d   = 1'b1;
          found_d  = 1'b1;
          fpos_d   = POS_W'(idx_next);
          status_d = STS_OK;
          state_d  = ST_IDLE;
        end else if (idx_next == count_q) begin
          done_d   = 1'b1;
          status_d = STS_OK;
          state_d  = ST_IDLE;
        end else begin
          mem_o.raddr = slot(head_q, idx_next[AW-1:0]);
          idx_d       = idx_next[AW-1:0];
        end
      end

      ST_SORT_FIRST: begin
        carry_d     = rdata_i;
        mem_o.raddr = slot(head_q, idx_q);
        state_d     = ST_SORT_STEP;
      end

      // carry holds the largest seen so far in this pass
      ST_SORT_STEP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = slot(head_q, idx_q - AW'(1));
        if ($signed(carry_q) > $signed(rdata_i)) begin
          mem_o.wdata = rdata_i;
        end else begin
          mem_o.wdata = carry_q;
          carry_d     = rdata_i;
        end
        if (idx_q == last_q) begin
          state_d = ST_SORT_END;
        end else begin
          mem_o.raddr = slot(head_q, idx_next[AW-1:0]);
          idx_d       = idx_next[AW-1:0];
        end
      end

      ST_SORT_END: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = slot(head_q, last_q);
        mem_o.wdata = carry_q;
        if (last_q == AW'(1)) begin
          done_d   = 1'b1;
          data_d   = '0;
          found_d  = 1'b0;
          fpos_d   = '0;
          status_d = STS_OK;
          state_d  = ST_IDLE;
        end else begin
          last_d      = last_q - AW'(1);
          mem_o.raddr = head_q;
          idx_d       = AW'(1);
          state_d     = ST_SORT_FIRST;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign data_out_o       = data_q;
  assign found_o          = found_q;
  assign found_position_o = fpos_q;
  assign status_o         = status_q;
  assign occupancy_o      = POS_W'(count_q);

endmodule

### sv/searchable_sortable_fifo.sv
// ----------------------------------------------------------------------------
// searchable_sortable_fifo
// Ring FIFO of Q16.16 values with enqueue, dequeue, search, update and sort.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+------------------
//   command | action_i value_i position_i               | start & !busy
//   result  | data_out_o found_o found_position_o       | done_o, one cycle
//           | status_o occupancy_o                      |
//   config  | cfg_data_i (capacity)                     | cfg_valid_i & cfg_ready_o
//
// enqueue, update, refused and empty commands: result the cycle after start
// dequeue: one entry RAM read, whose data is registered into data_out_o
// search: walks the entries from the head, stopping at the first match or after the last entry
// sort: bubble passes over the entry RAM
// reset clears state, pointers, occupancy and done_o and sets capacity to 16; the result side is never stalled
// ----------------------------------------------------------------------------
module searchable_sortable_fifo import ssf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]  position_i,
  output logic              done_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic              found_o,
  output logic [POS_W-1:0]  found_position_o,
  output logic [ST_W-1:0]   status_o,
  output logic [POS_W-1:0]  occupancy_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i
);

  logic [CAP_W-1:0]  cap_q;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  ssf_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .capacity_i       (cap_q),
    .mem_o            (mem_req),
    .rdata_i          (rdata),
    .done_o           (done_o),
    .data_out_o       (data_out_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .status_o         (status_o),
    .occupancy_o      (occupancy_o)
  );

  ssf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule
